// ----- rtl/plbc_pkg.sv -----
// Package for the piecewise-linear brightness curve unit.
// Holds field widths, register indexes, reset values and pipeline stage types.
// No dependencies.
`timescale 1ns / 1ps

package plbc_pkg;

	// Field widths
	localparam int MAX_POINTS = 7;
	localparam int LUX_BITS   = 14;
	localparam int PCT_BITS   = 7;
	localparam int FRAC_BITS  = 8;
	localparam int POINT_BITS = LUX_BITS + PCT_BITS;
	localparam int COUNT_BITS = 3;
	localparam int INDEX_BITS = 3;
	localparam int QUO_BITS   = PCT_BITS + FRAC_BITS;
	localparam int PROD_BITS  = LUX_BITS + PCT_BITS;
	localparam int DVD_BITS   = PROD_BITS + FRAC_BITS;

	// Value used when the curve has too few points
	localparam int FALLBACK_PCT = 50;

	typedef logic [LUX_BITS-1:0]   lux_t;
	typedef logic [PCT_BITS-1:0]   pct_t;
	typedef logic [POINT_BITS-1:0] point_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [INDEX_BITS-1:0] reg_idx_t;
	typedef logic [QUO_BITS-1:0]   bright_t;

	// Register indexes; breakpoint k sits at REG_FIRST_POINT + k.
	localparam reg_idx_t REG_POINT_COUNT = reg_idx_t'(0);
	localparam reg_idx_t REG_FIRST_POINT = reg_idx_t'(1);

	// Reset values of the registers
	localparam count_t COUNT_RESET = count_t'(5);
	localparam point_t POINT_RESET [MAX_POINTS] = '{
		point_t'(327680), point_t'(655410), point_t'(1147080), point_t'(1475060),
		point_t'(1639400), point_t'(0), point_t'(0)
	};

	// One divider stage: partial remainder, dividend bits shifting into quotient
	typedef struct packed {
		lux_t    rem;
		bright_t qd;
		lux_t    span;
		bright_t base;
		logic    neg;
		logic    flag;
	} div_t;

	// Extract the lux part of a breakpoint
	function automatic lux_t lux_of(input point_t p);
		return p[LUX_BITS-1:0];
	endfunction

	// Extract the brightness part of a breakpoint
	function automatic pct_t pct_of(input point_t p);
		return p[POINT_BITS-1:LUX_BITS];
	endfunction

endpackage

// ----- rtl/piecewise_linear_brightness_curve_unit.sv -----
// Top level of the piecewise-linear brightness curve unit.
// Depends on plbc_pkg for widths, register indexes and stage types.
`timescale 1ns / 1ps

// Maps an ambient light sample in lux to a display brightness percent with
// 8 fractional bits, read off a curve of up to seven breakpoints.
// Channels: the input channel (in_valid, in_ready, ambient_lux) and the
// output channel (out_valid, out_ready, brightness_fixed, too_few_points)
// each move one item per transfer. The configuration channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data) is always ready; index 0 sets the point
// count and indexes 1 to 7 set breakpoints 0 to 6 (lux in the low 14 bits,
// percent in the 7 bits above). Write it only while no item is in flight.
// An input transfer passes through one compare stage, one select stage, one
// multiply stage, 15 divider stages (one quotient bit each) and one output
// stage. Throughput: one item per cycle while the skid register is empty;
// the 15-stage restoring divider is fully pipelined.
// Reset clears all valid bits and loads the default five-point curve.
// When the receiver stalls, the finished result moves into a skid register
// and the pipeline takes one more step; it then holds until the skid drains.
module piecewise_linear_brightness_curve_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  plbc_pkg::lux_t     ambient_lux,
	output logic               out_valid,
	input  logic               out_ready,
	output plbc_pkg::bright_t  brightness_fixed,
	output logic               too_few_points,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  plbc_pkg::reg_idx_t cfg_index,
	input  plbc_pkg::point_t   cfg_data
);
	import plbc_pkg::*;

	// Configuration registers
	count_t point_count_q;
	point_t points_q [MAX_POINTS];

	// Pipeline registers
	logic                     valid_s1, interp_s1, flag_s1;
	lux_t                     lux_s1;
	logic [INDEX_BITS-1:0]    idx_s1;
	logic                     valid_s2, neg_s2, flag_s2;
	lux_t                     dist_s2, span_s2;
	pct_t                     db_s2;
	bright_t                  base_s2;
	logic                     valid_s3;
	div_t                     div_in_s3;
	logic                     div_valid_s [QUO_BITS];
	div_t                     div_s       [QUO_BITS];
	logic                     valid_s19, flag_s19;
	bright_t                  brt_s19;

	// Output skid register
	logic    skid_full_q, skid_flag_q;
	bright_t skid_brt_q;

	// Pipeline advance
	logic adv;

	// Stage 1 decision signals
	count_t                cnt;
	count_t                last_idx;
	logic                  fallback, lo, hi, found;
	logic [INDEX_BITS-1:0] seg_idx;
	logic [INDEX_BITS-1:0] idx_d;
	logic                  interp_d;

	// Stage 2 selection signals
	logic [INDEX_BITS-1:0] nxt_idx;
	lux_t                  x0, x1;
	pct_t                  b0, b1;

	// Stage 3 product
	logic [PROD_BITS-1:0] prod;
	logic [DVD_BITS-1:0]  dvd;

	// Divider step results
	div_t div_d [QUO_BITS];

	// Output stage sum
	bright_t result_d;

	assign cfg_ready = 1'b1;
	assign adv       = !skid_full_q;
	assign in_ready  = adv;

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= COUNT_RESET;
			for (int k = 0; k < MAX_POINTS; k++) begin
				points_q[k] <= POINT_RESET[k];
			end
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_POINT_COUNT) begin
				point_count_q <= cfg_data[COUNT_BITS-1:0];
			end else begin
				points_q[cfg_index - REG_FIRST_POINT] <= cfg_data;
			end
		end
	end

	// Stage 1: compare the sample against the curve and pick a segment.
	always_comb begin
		cnt      = (point_count_q > count_t'(MAX_POINTS)) ? count_t'(MAX_POINTS) : point_count_q;
		fallback = (cnt < count_t'(2));
		last_idx = fallback ? count_t'(0) : cnt - count_t'(1);
		lo       = (ambient_lux <= lux_of(points_q[0]));
		hi       = (ambient_lux >= lux_of(points_q[last_idx]));
		found    = 1'b0;
		seg_idx  = '0;
		// Scan from the top so the lowest matching segment wins.
		for (int i = MAX_POINTS - 2; i >= 0; i--) begin
			if ((count_t'(i + 1) < cnt) && (ambient_lux <= lux_of(points_q[i + 1]))) begin
				found   = 1'b1;
				seg_idx = INDEX_BITS'(i);
			end
		end
		if (fallback) begin
			idx_d    = '0;
			interp_d = 1'b0;
		end else if (lo) begin
			idx_d    = '0;
			interp_d = 1'b0;
		end else if (hi || !found) begin
			idx_d    = last_idx;
			interp_d = 1'b0;
		end else begin
			idx_d    = seg_idx;
			interp_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lux_s1    <= ambient_lux;
			idx_s1    <= idx_d;
			interp_s1 <= interp_d;
			flag_s1   <= fallback;
		end
	end

	// Stage 2: fetch the segment ends and form distance, span and rise.
	always_comb begin
		nxt_idx = interp_s1 ? idx_s1 + INDEX_BITS'(1) : idx_s1;
		x0      = lux_of(points_q[idx_s1]);
		x1      = lux_of(points_q[nxt_idx]);
		b0      = pct_of(points_q[idx_s1]);
		b1      = pct_of(points_q[nxt_idx]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flag_s2 <= flag_s1;
			base_s2 <= flag_s1 ? bright_t'(FALLBACK_PCT << FRAC_BITS)
			                   : bright_t'(b0) << FRAC_BITS;
			if (interp_s1) begin
				dist_s2 <= lux_s1 - x0;
				span_s2 <= x1 - x0;
				db_s2   <= (b1 >= b0) ? b1 - b0 : b0 - b1;
				neg_s2  <= (b1 < b0);
			end else begin
				// A zero rise gives a zero quotient; a unit span keeps the divider sane.
				dist_s2 <= '0;
				span_s2 <= lux_t'(1);
				db_s2   <= '0;
				neg_s2  <= 1'b0;
			end
		end
	end

	// Stage 3: multiply distance by rise and load the divider.
	always_comb begin
		prod = PROD_BITS'(dist_s2) * PROD_BITS'(db_s2);
		dvd  = DVD_BITS'(prod) << FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_in_s3.rem  <= dvd[DVD_BITS-1 -: LUX_BITS];
			div_in_s3.qd   <= dvd[QUO_BITS-1:0];
			div_in_s3.span <= span_s2;
			div_in_s3.base <= base_s2;
			div_in_s3.neg  <= neg_s2;
			div_in_s3.flag <= flag_s2;
		end
	end

	// Divider steps: each stage produces one quotient bit, MSB first.
	always_comb begin
		logic [LUX_BITS:0] trial;
		div_t              src;
		for (int k = 0; k < QUO_BITS; k++) begin
			src   = (k == 0) ? div_in_s3 : div_s[(k == 0) ? 0 : k - 1];
			trial = {src.rem, src.qd[QUO_BITS-1]};
			div_d[k] = src;
			if (trial >= {1'b0, src.span}) begin
				div_d[k].rem = LUX_BITS'(trial - {1'b0, src.span});
				div_d[k].qd  = {src.qd[QUO_BITS-2:0], 1'b1};
			end else begin
				div_d[k].rem = trial[LUX_BITS-1:0];
				div_d[k].qd  = {src.qd[QUO_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QUO_BITS; k++) begin
				div_valid_s[k] <= 1'b0;
			end
		end else if (adv) begin
			div_valid_s[0] <= valid_s3;
			for (int k = 1; k < QUO_BITS; k++) begin
				div_valid_s[k] <= div_valid_s[k - 1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < QUO_BITS; k++) begin
				div_s[k] <= div_d[k];
			end
		end
	end

	// Output stage: apply the signed offset to the segment base.
	assign result_d = div_s[QUO_BITS-1].neg ? div_s[QUO_BITS-1].base - div_s[QUO_BITS-1].qd
	                                        : div_s[QUO_BITS-1].base + div_s[QUO_BITS-1].qd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s19 <= 1'b0;
		end else if (adv) begin
			valid_s19 <= div_valid_s[QUO_BITS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			brt_s19  <= result_d;
			flag_s19 <= div_s[QUO_BITS-1].flag;
		end
	end

	// Skid register: catches the last stage when the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (out_ready) begin
				skid_full_q <= 1'b0;
			end
		end else if (valid_s19 && !out_ready) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q && valid_s19 && !out_ready) begin
			skid_brt_q  <= brt_s19;
			skid_flag_q <= flag_s19;
		end
	end

	// Result channel: the skid entry is older and goes first.
	assign out_valid        = skid_full_q || valid_s19;
	assign brightness_fixed = skid_full_q ? skid_brt_q : brt_s19;
	assign too_few_points   = skid_full_q ? skid_flag_q : flag_s19;

endmodule
